// ===== sv/triangular_matrix_product_chain_macros.svh =====
// Assertion macros shared by the triangular matrix product chain RTL.
// Depends on nothing; included by files that assert.
`ifndef TRIANGULAR_MATRIX_PRODUCT_CHAIN_MACROS_SVH
`define TRIANGULAR_MATRIX_PRODUCT_CHAIN_MACROS_SVH

// implication checked on every edge outside reset
`define TMPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tmpc_pkg.sv =====
// Package for the triangular matrix product chain: function codes, FSM
// states and controller/datapath command and status structs. No dependencies.
package tmpc_pkg;

    localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    localparam int ELEM_W = 16;
    localparam int PSUM_W = 36;
    localparam int RES_W  = 64;
    localparam int IDX_W  = 3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_S1    = 7'b0000010,  // first term of S: A^T*B
        ST_S2    = 7'b0000100,  // second term of S: B*A
        ST_SWR   = 7'b0001000,  // write S entry
        ST_R     = 7'b0010000,  // R accumulate
        ST_RDONE = 7'b0100000,  // drain multiplier pipe
        ST_EMIT  = 7'b1000000   // hand result to output register
    } state_t;

    typedef struct packed {
        logic             clr;       // clear accumulator
        logic             s_mac;     // issue S product
        logic             s_sel2;    // 0: A(k,i)*B(k,j), 1: B(i,k)*A(k,j)
        logic             s_write;   // store accumulator into S
        logic             r_mac;     // issue R product
        logic             emit;      // load output register
        logic             last;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;   // products still in flight
        logic out_full;    // output register holds a stalled word
    } dp_stat_t;

endpackage

// ===== sv/tmpc_ctrl.sv =====
// Controller FSM for the triangular matrix product chain: walks i, j, k.
// Depends on tmpc_pkg and the macros header.
`include "triangular_matrix_product_chain_macros.svh"

module tmpc_ctrl #(
    parameter int DIM_W = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIM_W-1:0]        last_idx,   // N-1
    input  tmpc_pkg::dp_stat_t      stat,
    output tmpc_pkg::dp_cmd_t       cmd,
    output logic                    busy
);

    tmpc_pkg::state_t state_reg, state_next;
    logic [DIM_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic             rphase_reg, rphase_next;

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        rphase_next = rphase_reg;
        cmd         = '0;
        cmd.i       = tmpc_pkg::IDX_W'(i_reg);
        cmd.j       = tmpc_pkg::IDX_W'(j_reg);
        cmd.k       = tmpc_pkg::IDX_W'(k_reg);
        cmd.last    = (i_reg == last_idx) && (j_reg == last_idx);
        unique case (state_reg)
            tmpc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    rphase_next = 1'b0;
                    cmd.clr     = 1'b1;
                    state_next  = tmpc_pkg::ST_S1;
                end
            end
            tmpc_pkg::ST_S1:
            begin
                cmd.s_mac = 1'b1;
                if (k_reg == i_reg)
                begin
                    k_next     = '0;
                    state_next = tmpc_pkg::ST_S2;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            tmpc_pkg::ST_S2:
            begin
                cmd.s_mac  = 1'b1;
                cmd.s_sel2 = 1'b1;
                if (k_reg == j_reg)
                begin
                    k_next     = '0;
                    state_next = tmpc_pkg::ST_RDONE;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            tmpc_pkg::ST_R:
            begin
                cmd.r_mac = 1'b1;
                if (k_reg == last_idx)
                begin
                    k_next     = '0;
                    state_next = tmpc_pkg::ST_RDONE;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            tmpc_pkg::ST_RDONE:
            begin
                if (!stat.pipe_busy)
                    state_next = rphase_reg ? tmpc_pkg::ST_EMIT : tmpc_pkg::ST_SWR;
            end
            tmpc_pkg::ST_SWR:
            begin
                cmd.s_write = 1'b1;
                cmd.clr     = 1'b1;
                if (j_reg == last_idx)
                begin
                    j_next = '0;
                    if (i_reg == last_idx)
                    begin
                        i_next      = '0;
                        rphase_next = 1'b1;
                        state_next  = tmpc_pkg::ST_R;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = tmpc_pkg::ST_S1;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = tmpc_pkg::ST_S1;
                end
            end
            tmpc_pkg::ST_EMIT:
            begin
                if (!stat.out_full)
                begin
                    cmd.emit = 1'b1;
                    cmd.clr  = 1'b1;
                    if (j_reg == last_idx)
                    begin
                        j_next = '0;
                        if (i_reg == last_idx)
                            state_next = tmpc_pkg::ST_IDLE;
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = tmpc_pkg::ST_R;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = tmpc_pkg::ST_R;
                    end
                end
            end
            default:
                state_next = tmpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tmpc_pkg::ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            rphase_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            rphase_reg <= rphase_next;
        end
    end

    assign busy = (state_reg != tmpc_pkg::ST_IDLE);

    `TMPC_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
    `TMPC_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !stat.out_full, "emit into full output")
    `TMPC_ASSERT_IMP(a_s1_k, clk, rst_n, state_reg == tmpc_pkg::ST_S1, k_reg <= i_reg,
        "S1 index past diagonal")
    `TMPC_ASSERT_NEXT(a_swr_clr, clk, rst_n, cmd.s_write,
        state_reg == tmpc_pkg::ST_S1 || state_reg == tmpc_pkg::ST_R, "bad step after S write")

endmodule

// ===== sv/tmpc_datapath.sv =====
// Datapath: A, B and S memories, one registered multiplier, accumulator and
// output register. Depends on tmpc_pkg.
module tmpc_datapath #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_a,
    input  logic                              wr_b,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [tmpc_pkg::ELEM_W-1:0] wr_data,
    input  tmpc_pkg::dp_cmd_t                 cmd,
    output tmpc_pkg::dp_stat_t                stat,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [tmpc_pkg::IDX_W-1:0]        out_row,
    output logic [tmpc_pkg::IDX_W-1:0]        out_col,
    output logic signed [tmpc_pkg::RES_W-1:0] out_val,
    output logic                              out_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic signed [tmpc_pkg::ELEM_W-1:0] a_mem [DEPTH];
    logic signed [tmpc_pkg::ELEM_W-1:0] b_mem [DEPTH];
    logic signed [tmpc_pkg::PSUM_W-1:0] s_mem [DEPTH];

    function automatic logic [AW-1:0] addr(input logic [tmpc_pkg::IDX_W-1:0] r,
                                           input logic [tmpc_pkg::IDX_W-1:0] c);
        addr = AW'(r * MAX_DIM + c);
    endfunction

    // read addresses per command
    logic [AW-1:0] a_ra, b_ra, s_ra;
    always_comb
    begin
        if (cmd.s_sel2)
        begin
            a_ra = addr(cmd.k, cmd.j);
            b_ra = addr(cmd.i, cmd.k);
        end
        else if (cmd.r_mac)
        begin
            a_ra = addr(cmd.k, cmd.j);
            b_ra = addr(cmd.j, cmd.k);
        end
        else
        begin
            a_ra = addr(cmd.k, cmd.i);
            b_ra = addr(cmd.k, cmd.j);
        end
        s_ra = addr(cmd.i, cmd.k);
    end

    logic signed [tmpc_pkg::ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic signed [tmpc_pkg::PSUM_W-1:0] s_rd_reg;
    logic                               v1_reg, r1_reg, v2_reg;
    logic signed [51:0]                 prod_reg;
    logic signed [tmpc_pkg::RES_W-1:0]  acc_reg;
    logic signed [tmpc_pkg::PSUM_W-1:0] mul_l;
    logic signed [tmpc_pkg::ELEM_W-1:0] mul_r;

    always_ff @(posedge clk)
    begin
        if (wr_a)
            a_mem[wr_addr] <= wr_data;
        if (wr_b)
            b_mem[wr_addr] <= wr_data;
        if (cmd.s_write)
            s_mem[addr(cmd.i, cmd.j)] <= acc_reg[tmpc_pkg::PSUM_W-1:0];
        a_rd_reg <= a_mem[a_ra];
        b_rd_reg <= b_mem[b_ra];
        s_rd_reg <= s_mem[s_ra];
    end

    // stage 2: one multiply; S term uses A, R term uses S
    assign mul_l = r1_reg ? s_rd_reg : tmpc_pkg::PSUM_W'(a_rd_reg);
    assign mul_r = b_rd_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 52'(mul_l * mul_r);
        if (cmd.clr)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + tmpc_pkg::RES_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            r1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.s_mac | cmd.r_mac;
            r1_reg <= cmd.r_mac;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.emit)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row  <= cmd.i;
            out_col  <= cmd.j;
            out_val  <= acc_reg;
            out_last <= cmd.last;
        end
    end

    assign stat.pipe_busy = v1_reg | v2_reg;
    assign stat.out_full  = out_valid & out_stall;

endmodule

// ===== sv/triangular_matrix_product_chain.sv =====
// Top level of the triangular matrix product chain: input handshake,
// size register, controller and datapath. Depends on tmpc_pkg, tmpc_ctrl, tmpc_datapath.
//
//  channel  | direction | handshake          | words
//  input    | in        | valid / stall      | func, row_index, col_index, element_value
//  result   | out       | valid / stall      | result_row, result_col, product_value, last_of_run
//  config   | in        | cfg_valid/cfg_ready| size_in_use
//
// A load is accepted whenever in_stall is low. Compute time with no result stalls is set by
// the single shared multiplier, its two-stage read/multiply pipe and the drain before each
// write or emit.
// Input stall is held high from compute start until the last word enters the output register.
// A stalled result word holds in the output register; the walk pauses at the next emit.
// Reset clears control state only; memories are undefined until loaded.
module triangular_matrix_product_chain #(
    parameter int MAX_DIM = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [2:0]  row_index,
    input  logic [2:0]  col_index,
    input  logic signed [15:0] element_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_row,
    output logic [2:0]  result_col,
    output logic signed [63:0] product_value,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);

    logic [3:0]           size_reg;
    logic [DIM_W-1:0]     last_idx;
    logic                 busy, accept, start, in_range;
    tmpc_pkg::dp_cmd_t    cmd;
    tmpc_pkg::dp_stat_t   stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= 4'(MAX_DIM);
        else if (cfg_valid && cfg_ready)
            size_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (size_reg == 4'd0)
            last_idx = '0;
        else if (size_reg > 4'(MAX_DIM))
            last_idx = DIM_W'(MAX_DIM - 1);
        else
            last_idx = DIM_W'(size_reg - 4'd1);
    end

    assign in_stall = busy;
    assign accept   = in_valid && !in_stall;
    assign start    = accept && (func == tmpc_pkg::FUNC_COMPUTE);
    assign in_range = (4'(row_index) < 4'(MAX_DIM)) && (4'(col_index) < 4'(MAX_DIM));

    tmpc_ctrl #(.DIM_W(DIM_W)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_idx (last_idx),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    tmpc_datapath #(.MAX_DIM(MAX_DIM), .AW(AW)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_a      (accept && func == tmpc_pkg::FUNC_LOAD_A && in_range),
        .wr_b      (accept && func == tmpc_pkg::FUNC_LOAD_B && in_range),
        .wr_addr   (AW'(row_index * MAX_DIM + col_index)),
        .wr_data   (element_value),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_row   (result_row),
        .out_col   (result_col),
        .out_val   (product_value),
        .out_last  (last_of_run)
    );

endmodule
